@@ rtl/ght_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ght_pkg: shared definitions of the generational handle table
// Slot count, field widths, operation codes and the slot entry layout.
// ----------------------------------------------------------------------------
package ght_pkg;

  localparam int SLOT_COUNT = 1024;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int GEN_W      = 16;
  localparam int HANDLE_W   = 32;
  localparam int KIND_W     = 2;
  localparam int CNT_W      = SLOT_W + 1;
  localparam int ENTRY_W    = GEN_W + 1;

  localparam logic [KIND_W-1:0] KIND_ALLOCATE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RELEASE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIND     = 2'd2;

  typedef struct packed {
    logic             used;
    logic [GEN_W-1:0] gen;
  } entry_t;

endpackage

@@ rtl/ght_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ght_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module ght_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/generational_handle_table_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generational_handle_table_core: slot table handing out generation handles
// Allocate, release and find over a table of slots, each with a used mark
// and a 16-bit generation; handles are slot << 16 | generation.
// ----------------------------------------------------------------------------
// Operation: allocate probes slots from the round-robin pointer, one probe
//   a cycle through the slot RAM read port, until a free one is found (1 to
//   SLOT_COUNT probes). Release and find do one RAM read, then one check. An
//   allocate on a full table, an out-of-range slot or an unknown kind answers
//   in the cycle after accept. One transaction at a time: busy is high while
//   a scan or lookup runs. Reset: a clearing pass zeroes every slot entry,
//   with busy high. Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module generational_handle_table_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [ght_pkg::KIND_W-1:0]   kind_i,
  input  logic [ght_pkg::HANDLE_W-1:0] handle_i,
  output logic                         done_o,
  output logic [ght_pkg::HANDLE_W-1:0] result_handle_o,
  output logic                         ok_o
);

  // Sequencer codes
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_LOOK  = 2'd3;

  localparam logic [ght_pkg::SLOT_W-1:0] LAST_SLOT =
    ght_pkg::SLOT_W'(ght_pkg::SLOT_COUNT - 1);

  // Control state
  logic [1:0]                  state_q, state_d;
  logic [ght_pkg::SLOT_W-1:0]  clr_q, clr_d;
  logic [ght_pkg::SLOT_W-1:0]  chk_q, chk_d;
  logic [ght_pkg::SLOT_W-1:0]  next_slot_q, next_slot_d;
  logic [ght_pkg::CNT_W-1:0]   used_cnt_q, used_cnt_d;
  logic                        is_release_q, is_release_d;
  logic                        done_q, done_d;

  // Payload registers
  logic [ght_pkg::HANDLE_W-1:0] handle_q, handle_d;
  logic [ght_pkg::HANDLE_W-1:0] res_q, res_d;
  logic                         ok_q, ok_d;

  // Slot RAM port signals
  logic                        wr_en;
  logic [ght_pkg::SLOT_W-1:0]  wr_addr;
  ght_pkg::entry_t             wr_entry;
  logic [ght_pkg::SLOT_W-1:0]  rd_addr;
  ght_pkg::entry_t             rd_entry;

  logic                        accept;
  logic                        table_full;
  logic                        slot_in_range;
  logic [ght_pkg::SLOT_W-1:0]  in_slot;
  logic [ght_pkg::SLOT_W-1:0]  chk_inc;
  logic [ght_pkg::SLOT_W-1:0]  held_slot;
  logic [ght_pkg::GEN_W-1:0]   gen_inc;
  logic [ght_pkg::GEN_W-1:0]   gen_new;
  logic                        live;

  ght_ram #(
    .WIDTH (ght_pkg::ENTRY_W),
    .DEPTH (ght_pkg::SLOT_COUNT)
  ) u_slot_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_entry),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_entry)
  );

  assign busy       = (state_q != ST_IDLE);
  assign accept     = start && !busy;
  assign table_full = (used_cnt_q == ght_pkg::CNT_W'(ght_pkg::SLOT_COUNT));

  // Slot field of the incoming handle; range check on the full 16-bit field
  assign in_slot       = handle_i[16 +: ght_pkg::SLOT_W];
  assign slot_in_range = ({1'b0, handle_i[31:16]} < 17'(ght_pkg::SLOT_COUNT));
  assign held_slot     = handle_q[16 +: ght_pkg::SLOT_W];

  // Round-robin step with wrap at the last slot
  assign chk_inc = (chk_q == LAST_SLOT) ? '0 : chk_q + ght_pkg::SLOT_W'(1);

  // Next generation, skipping zero on wrap
  assign gen_inc = rd_entry.gen + ght_pkg::GEN_W'(1);
  assign gen_new = (gen_inc == '0) ? ght_pkg::GEN_W'(1) : gen_inc;

  assign live = rd_entry.used && (rd_entry.gen == handle_q[ght_pkg::GEN_W-1:0]);

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    chk_d        = chk_q;
    next_slot_d  = next_slot_q;
    used_cnt_d   = used_cnt_q;
    is_release_d = is_release_q;
    done_d       = 1'b0;
    handle_d     = handle_q;
    res_d        = res_q;
    ok_d         = ok_q;
    wr_en        = 1'b0;
    wr_addr      = chk_q;
    wr_entry     = '0;
    rd_addr      = chk_inc;

    case (state_q)
      ST_CLEAR: begin
        // Sweep every entry to free / generation zero
        wr_en   = 1'b1;
        wr_addr = clr_q;
        clr_d   = clr_q + ght_pkg::SLOT_W'(1);
        if (clr_q == LAST_SLOT) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        // Issue the first RAM read in the accept cycle
        rd_addr = (kind_i == ght_pkg::KIND_ALLOCATE) ? next_slot_q : in_slot;
        if (accept) begin
          handle_d     = handle_i;
          is_release_d = (kind_i == ght_pkg::KIND_RELEASE);
          case (kind_i)
            ght_pkg::KIND_ALLOCATE: begin
              if (table_full) begin
                done_d = 1'b1;
                ok_d   = 1'b0;
                res_d  = '0;
              end else begin
                chk_d   = next_slot_q;
                state_d = ST_SCAN;
              end
            end
            ght_pkg::KIND_RELEASE, ght_pkg::KIND_FIND: begin
              if (slot_in_range) begin
                state_d = ST_LOOK;
              end else begin
                done_d = 1'b1;
                ok_d   = 1'b0;
                res_d  = '0;
              end
            end
            default: begin
              // Unknown kind: answer a miss right away
              done_d = 1'b1;
              ok_d   = 1'b0;
              res_d  = '0;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // rd_entry holds the entry of chk_q; a free slot is known to exist
        if (!rd_entry.used) begin
          wr_en         = 1'b1;
          wr_addr       = chk_q;
          wr_entry.used = 1'b1;
          wr_entry.gen  = gen_new;
          res_d         = {16'(chk_q), gen_new};
          ok_d          = 1'b1;
          done_d        = 1'b1;
          next_slot_d   = chk_inc;
          used_cnt_d    = used_cnt_q + ght_pkg::CNT_W'(1);
          state_d       = ST_IDLE;
        end else begin
          chk_d   = chk_inc;
          rd_addr = chk_inc;
        end
      end

      ST_LOOK: begin
        done_d  = 1'b1;
        state_d = ST_IDLE;
        if (live) begin
          ok_d  = 1'b1;
          res_d = handle_q;
          if (is_release_q) begin
            // Drop the used mark, keep the generation
            wr_en         = 1'b1;
            wr_addr       = held_slot;
            wr_entry.used = 1'b0;
            wr_entry.gen  = rd_entry.gen;
            used_cnt_d    = used_cnt_q - ght_pkg::CNT_W'(1);
          end
        end else begin
          ok_d  = 1'b0;
          res_d = '0;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      chk_q        <= '0;
      next_slot_q  <= '0;
      used_cnt_q   <= '0;
      is_release_q <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      chk_q        <= chk_d;
      next_slot_q  <= next_slot_d;
      used_cnt_q   <= used_cnt_d;
      is_release_q <= is_release_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    handle_q <= handle_d;
    res_q    <= res_d;
    ok_q     <= ok_d;
  end

  assign done_o          = done_q;
  assign result_handle_o = res_q;
  assign ok_o            = ok_q;

  // A miss always answers a zero handle
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !ok_o |-> result_handle_o == '0)
    else $error("miss with nonzero result handle");

  // A hit never carries generation zero
  a_hit_gen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && ok_o |-> result_handle_o[ght_pkg::GEN_W-1:0] != '0)
    else $error("hit with generation zero");

  // The scan only runs while a free slot exists
  a_scan_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> !table_full)
    else $error("scan on a full table");

  // Allocate on a full table fails on the next cycle
  a_full_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && kind_i == ght_pkg::KIND_ALLOCATE && table_full |=> done_o && !ok_o)
    else $error("full-table allocate did not fail at once");

  // The used count never exceeds the slot count
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_cnt_q <= ght_pkg::CNT_W'(ght_pkg::SLOT_COUNT))
    else $error("used count out of range");

endmodule

@@ tb/generational_handle_table_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generational_handle_table_checker: slot table predictor and scoreboard
// Watches the command and result ports of the handle table, keeps its own
// copy of the slot table, predicts the answer to each accepted transaction
// and compares every strobed result against the oldest prediction.
// ----------------------------------------------------------------------------
module generational_handle_table_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_i,
  input  logic [ght_pkg::KIND_W-1:0]   kind_i,
  input  logic [ght_pkg::HANDLE_W-1:0] handle_i,
  input  logic                         done_i,
  input  logic [ght_pkg::HANDLE_W-1:0] result_handle_i,
  input  logic                         ok_i,
  output int                           mismatch_count_o,
  output int                           pending_count_o,
  output int                           hit_count_o,
  output int                           full_count_o
);

  typedef struct packed {
    logic [ght_pkg::HANDLE_W-1:0] handle;
    logic                         ok;
  } table_answer_t;

  logic                      slot_taken [ght_pkg::SLOT_COUNT];
  logic [ght_pkg::GEN_W-1:0] slot_gen   [ght_pkg::SLOT_COUNT];
  int                        alloc_ptr;
  table_answer_t             answer_q [$];
  int                        n_mismatch;
  int                        n_hit;
  int                        n_full;

  function automatic logic handle_is_live(input logic [ght_pkg::HANDLE_W-1:0] h);
    int slot;
    slot = int'(h[ght_pkg::HANDLE_W-1:ght_pkg::GEN_W]);
    if (slot >= ght_pkg::SLOT_COUNT) return 1'b0;
    return slot_taken[slot] && (slot_gen[slot] == h[ght_pkg::GEN_W-1:0]);
  endfunction

  // Apply one command to the shadow table and return its answer.
  function automatic table_answer_t table_op_answer(
    input logic [ght_pkg::KIND_W-1:0]   kind,
    input logic [ght_pkg::HANDLE_W-1:0] h
  );
    table_answer_t             ans;
    int                        idx;
    logic                      found;
    logic [ght_pkg::GEN_W-1:0] g;
    logic [15:0]               slot_bits;
    ans   = '0;
    found = 1'b0;
    case (kind)
      ght_pkg::KIND_ALLOCATE: begin
        for (int i = 0; i < ght_pkg::SLOT_COUNT && !found; i++) begin
          idx = (alloc_ptr + i) % ght_pkg::SLOT_COUNT;
          if (!slot_taken[idx]) begin
            g = slot_gen[idx] + 1'b1;
            if (g == '0) g = ght_pkg::GEN_W'(1);
            slot_gen[idx]   = g;
            slot_taken[idx] = 1'b1;
            alloc_ptr       = (idx + 1) % ght_pkg::SLOT_COUNT;
            slot_bits       = idx[15:0];
            ans.handle      = {slot_bits, g};
            ans.ok          = 1'b1;
            found           = 1'b1;
          end
        end
      end
      ght_pkg::KIND_RELEASE: begin
        if (handle_is_live(h)) begin
          slot_taken[int'(h[ght_pkg::HANDLE_W-1:ght_pkg::GEN_W])] = 1'b0;
          ans.handle = h;
          ans.ok     = 1'b1;
        end
      end
      ght_pkg::KIND_FIND: begin
        if (handle_is_live(h)) begin
          ans.handle = h;
          ans.ok     = 1'b1;
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    table_answer_t want;
    if (!rst_ni) begin
      for (int i = 0; i < ght_pkg::SLOT_COUNT; i++) begin
        slot_taken[i] = 1'b0;
        slot_gen[i]   = '0;
      end
      alloc_ptr  = 0;
      n_mismatch = 0;
      n_hit      = 0;
      n_full     = 0;
      answer_q.delete();
      mismatch_count_o <= 0;
      pending_count_o  <= 0;
      hit_count_o      <= 0;
      full_count_o     <= 0;
    end else begin
      // Retire the result first: a new command may be accepted on the same edge.
      if (done_i) begin
        if (answer_q.size() == 0) begin
          $error("unexpected result: result_handle %h ok %b", result_handle_i, ok_i);
          n_mismatch++;
        end else begin
          want = answer_q.pop_front();
          if (result_handle_i !== want.handle) begin
            $error("result_handle: expected %h, actual %h", want.handle, result_handle_i);
            n_mismatch++;
          end
          if (ok_i !== want.ok) begin
            $error("ok: expected %b, actual %b", want.ok, ok_i);
            n_mismatch++;
          end
        end
      end
      if (start_i && !busy_i) begin
        want = table_op_answer(kind_i, handle_i);
        if (want.ok) n_hit++;
        if (kind_i == ght_pkg::KIND_ALLOCATE && !want.ok) n_full++;
        answer_q.push_back(want);
      end
      mismatch_count_o <= n_mismatch;
      pending_count_o  <= answer_q.size();
      hit_count_o      <= n_hit;
      full_count_o     <= n_full;
    end
  end

endmodule

@@ tb/generational_handle_table_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generational_handle_table_core_tb: allocate, release and find stimulus
// Drives a directed opening and three random phases with different sender
// gap rates; a checker beside the block predicts every answer, and this
// module reports the verdict.
// ----------------------------------------------------------------------------
module generational_handle_table_core_tb;

  // Kind code with no operation behind it; the block must answer a miss.
  localparam logic [ght_pkg::KIND_W-1:0] KIND_NONE = 2'd3;

  localparam int RANDOM_OPS   = 380;
  localparam int POOL_DEPTH   = 512;
  // Longest quiet stretch: the clearing pass after reset or an allocate that
  // probes every slot, plus a sender gap.
  localparam int QUIET_LIMIT  = 20 * ght_pkg::SLOT_COUNT;
  localparam int SETTLE_TICKS = 20;

  logic                         clk           = 1'b0;
  logic                         rst_n         = 1'b0;
  logic                         start         = 1'b0;
  logic [ght_pkg::KIND_W-1:0]   kind          = ght_pkg::KIND_ALLOCATE;
  logic [ght_pkg::HANDLE_W-1:0] handle        = '0;
  logic                         busy;
  logic                         done;
  logic [ght_pkg::HANDLE_W-1:0] result_handle;
  logic                         ok;

  int mismatch_count;
  int pending_count;
  int hit_count;
  int full_count;

  int sender_gap_pct = 0;
  int quiet_cycles   = 0;
  int n_alloc        = 0;
  int n_release      = 0;
  int n_find         = 0;
  int n_unknown      = 0;

  // Handles seen in successful answers; live and stale ones both feed stimulus.
  logic [ght_pkg::HANDLE_W-1:0] handle_pool [$];

  always #10 clk = ~clk;

  generational_handle_table_core u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .start           (start),
    .busy            (busy),
    .kind_i          (kind),
    .handle_i        (handle),
    .done_o          (done),
    .result_handle_o (result_handle),
    .ok_o            (ok)
  );

  generational_handle_table_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start_i          (start),
    .busy_i           (busy),
    .kind_i           (kind),
    .handle_i         (handle),
    .done_i           (done),
    .result_handle_i  (result_handle),
    .ok_i             (ok),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count),
    .hit_count_o      (hit_count),
    .full_count_o     (full_count)
  );

  // Collect handles from successful answers; once the pool is full,
  // overwrite a random entry so that recent handles keep showing up.
  always @(posedge clk) begin
    if (rst_n && done && ok) begin
      if (handle_pool.size() < POOL_DEPTH) begin
        handle_pool.push_back(result_handle);
      end else begin
        handle_pool[$urandom_range(POOL_DEPTH - 1)] = result_handle;
      end
    end
  end

  // Watchdog: end the run when neither a command nor a result moves for too
  // long. Reset cycles do not count; the clearing pass after reset does.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || done) begin
        quiet_cycles <= 0;
      end else begin
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("watchdog: no transaction for %0d cycles", quiet_cycles);
          $display("Mismatches found");
          $finish;
        end
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Present one command and hold it until the block takes it. Start stays high
  // on return so that a back-to-back command needs no second assignment in the
  // same step; a gap lowers it first and waits before raising it again.
  task automatic issue_op(input logic [ght_pkg::KIND_W-1:0]   k,
                          input logic [ght_pkg::HANDLE_W-1:0] h);
    if ($urandom_range(99) < sender_gap_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_gap_pct);
    end
    start  <= 1'b1;
    kind   <= k;
    handle <= h;
    do @(posedge clk); while (busy);
    case (k)
      ght_pkg::KIND_ALLOCATE: n_alloc++;
      ght_pkg::KIND_RELEASE:  n_release++;
      ght_pkg::KIND_FIND:     n_find++;
      default:                n_unknown++;
    endcase
  endtask

  // Drop start and hold off until every outstanding transaction has answered.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  function automatic logic [ght_pkg::HANDLE_W-1:0] pick_pool_handle();
    if (handle_pool.size() == 0) return $urandom;
    return handle_pool[$urandom_range(handle_pool.size() - 1)];
  endfunction

  // Mostly well-formed traffic: allocations, and releases and finds of handles
  // the block gave out earlier. The rest is corrupted handles, random
  // in-range slots, fully random handles and the unused kind code.
  task automatic issue_random_op();
    int                           roll;
    int                           slot_sel;
    logic [ght_pkg::HANDLE_W-1:0] h;
    logic [ght_pkg::GEN_W-1:0]    gen_sel;
    roll     = $urandom_range(99);
    h        = pick_pool_handle();
    slot_sel = $urandom_range(ght_pkg::SLOT_COUNT - 1);
    gen_sel  = ght_pkg::GEN_W'($urandom);
    if (roll < 40) begin
      issue_op(ght_pkg::KIND_ALLOCATE, $urandom);
    end else if (roll < 65) begin
      issue_op(ght_pkg::KIND_RELEASE, h);
    end else if (roll < 85) begin
      issue_op(ght_pkg::KIND_FIND, h);
    end else if (roll < 91) begin
      // Flip one bit: a stale generation or another slot.
      issue_op(roll[0] ? ght_pkg::KIND_RELEASE : ght_pkg::KIND_FIND,
               h ^ (32'd1 << $urandom_range(31)));
    end else if (roll < 94) begin
      issue_op(roll[0] ? ght_pkg::KIND_RELEASE : ght_pkg::KIND_FIND,
               {slot_sel[15:0], gen_sel});
    end else if (roll < 97) begin
      issue_op(roll[0] ? ght_pkg::KIND_RELEASE : ght_pkg::KIND_FIND, $urandom);
    end else begin
      issue_op(KIND_NONE, $urandom);
    end
  endtask

  initial begin
    int n;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening: misses on an empty table, the first allocations,
    // stale and freed handles, slots past the end and the unused kind code.
    sender_gap_pct = 33;
    issue_op(ght_pkg::KIND_FIND,     {16'd0, 16'd0});
    issue_op(ght_pkg::KIND_RELEASE,  {16'd0, 16'd0});
    issue_op(ght_pkg::KIND_ALLOCATE, 32'hFFFF_FFFF);
    issue_op(ght_pkg::KIND_ALLOCATE, 32'h0000_0000);
    issue_op(ght_pkg::KIND_FIND,     {16'd0, 16'd1});
    issue_op(ght_pkg::KIND_FIND,     {16'd0, 16'd2});
    issue_op(ght_pkg::KIND_FIND,     {16'd0, 16'd0});
    issue_op(ght_pkg::KIND_RELEASE,  {16'd0, 16'd1});
    issue_op(ght_pkg::KIND_RELEASE,  {16'd0, 16'd1});
    issue_op(ght_pkg::KIND_FIND,     {16'd0, 16'd1});
    issue_op(KIND_NONE,              32'hFFFF_FFFF);
    issue_op(KIND_NONE,              {16'd1, 16'd1});
    issue_op(ght_pkg::KIND_FIND,     32'hFFFF_FFFF);
    issue_op(ght_pkg::KIND_RELEASE,  {16'(ght_pkg::SLOT_COUNT), 16'd1});
    issue_op(ght_pkg::KIND_FIND,     {16'(ght_pkg::SLOT_COUNT - 1), 16'd0});
    issue_op(ght_pkg::KIND_ALLOCATE, 32'h5555_AAAA);
    issue_op(ght_pkg::KIND_RELEASE,  {16'd1, 16'd1});
    issue_op(ght_pkg::KIND_ALLOCATE, 32'hAAAA_5555);
    issue_op(ght_pkg::KIND_FIND,     {16'd1, 16'd1});
    issue_op(ght_pkg::KIND_FIND,     {16'd2, 16'd1});
    drain_results();

    // Random phases: moderate sender gaps, heavy gaps, then back-to-back.
    // Each phase ends with a full drain before the next one starts.
    sender_gap_pct = 33;
    for (n = 0; n < RANDOM_OPS / 3; n++) issue_random_op();
    drain_results();
    sender_gap_pct = 69;
    for (n = 0; n < RANDOM_OPS / 3; n++) issue_random_op();
    drain_results();
    sender_gap_pct = 0;
    for (n = 0; n < RANDOM_OPS - 2 * (RANDOM_OPS / 3); n++) issue_random_op();

    drain_results();
    repeat (SETTLE_TICKS) @(posedge clk);

    // Generation wrap needs tens of thousands of reuses of one slot at this
    // table size, so it is left to the predictor rather than reached here.
    $display("Covered %0d transactions: %0d allocate, %0d release, %0d find, %0d unknown kind",
             n_alloc + n_release + n_find + n_unknown, n_alloc, n_release, n_find, n_unknown);
    $display("%0d answers hit, %0d allocations refused on a full table", hit_count, full_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ generational_handle_table_core.f @@
rtl/ght_pkg.sv
rtl/ght_ram.sv
rtl/generational_handle_table_core.sv
tb/generational_handle_table_checker.sv
tb/generational_handle_table_core_tb.sv
